// File: hdl/grid_dda_ray_caster_unit_defines.svh
// ----------------------------------------------------------------------------
// grid_dda_ray_caster_unit_defines.svh
// Assertion macros for the ray caster datapath.
// ----------------------------------------------------------------------------
`ifndef GRID_DDA_RAY_CASTER_UNIT_DEFINES_SVH
`define GRID_DDA_RAY_CASTER_UNIT_DEFINES_SVH

// checked only out of reset
`define GDRC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define GDRC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/gdrc_pkg.sv
// ----------------------------------------------------------------------------
// gdrc_pkg
// Types, constants and helpers for the grid DDA ray caster.
// ----------------------------------------------------------------------------
package gdrc_pkg;

  localparam int GRID_WIDTH  = 64;
  localparam int GRID_HEIGHT = 64;
  localparam int DEPTH       = GRID_WIDTH * GRID_HEIGHT;
  localparam int ADDR_W      = $clog2(DEPTH);
  localparam int GW_BITS     = $clog2(GRID_WIDTH);
  localparam int GH_BITS     = $clog2(GRID_HEIGHT);
  localparam int MAX_BITS    = (GW_BITS > GH_BITS) ? GW_BITS : GH_BITS;
  // walk coordinates: grid range plus up to ~260 steps off either edge
  localparam int COORD_W     = ((MAX_BITS > 9) ? MAX_BITS : 9) + 2;
  localparam int CNT_W       = (ADDR_W > 5) ? ADDR_W : 5;

  localparam int SQRT_ITER   = 16;
  localparam int DIV_ITER    = 24;

  localparam logic [7:0]  MAX_DIST_RESET = 8'd100;
  localparam logic [15:0] SAT16          = 16'hFFFF;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_SQX, ST_SQY, ST_SQSUM, ST_SQRT,
    ST_DIVX_INIT, ST_DIVX, ST_DIVY_INIT, ST_DIVY,
    ST_LENX, ST_LENY, ST_WSTART, ST_WALK,
    ST_HX, ST_HY, ST_HYF, ST_FIN
  } state_t;

  typedef enum logic [4:0] {
    DP_NOP, DP_CLEAR, DP_ACCEPT, DP_SQX, DP_SQY, DP_SQSUM, DP_SQRT,
    DP_DIVX_INIT, DP_DIV, DP_DIVY_INIT, DP_LENX, DP_LENY, DP_WSTART,
    DP_WALK, DP_HX, DP_HY, DP_HYF, DP_FIN
  } dp_op_t;

  typedef struct packed {
    dp_op_t              op;
    logic [ADDR_W-1:0]   addr;
  } dp_cmd_t;

  typedef struct packed {
    logic is_cast;
    logic walk_hit;
    logic walk_end;
    logic out_busy;
  } dp_sts_t;

  function automatic logic [ADDR_W-1:0] cell_addr(input int x, input int y);
    return ADDR_W'(y * GRID_WIDTH + x);
  endfunction

endpackage

// File: hdl/gdrc_ctrl.sv
// ----------------------------------------------------------------------------
// gdrc_ctrl
// Sequencer: clear sweep, set-up arithmetic, walk and result hand-off.
// ----------------------------------------------------------------------------
module gdrc_ctrl
  import gdrc_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_tvalid,
  output logic    in_tready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               accept;

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR:     if (cnt_r == CNT_W'(DEPTH - 1)) state_nxt = ST_IDLE;
      ST_IDLE:      if (accept && sts.is_cast) state_nxt = ST_SQX;
      ST_SQX:       state_nxt = ST_SQY;
      ST_SQY:       state_nxt = ST_SQSUM;
      ST_SQSUM:     state_nxt = ST_SQRT;
      ST_SQRT:      if (cnt_r == CNT_W'(SQRT_ITER - 1)) state_nxt = ST_DIVX_INIT;
      ST_DIVX_INIT: state_nxt = ST_DIVX;
      ST_DIVX:      if (cnt_r == CNT_W'(DIV_ITER - 1)) state_nxt = ST_DIVY_INIT;
      ST_DIVY_INIT: state_nxt = ST_DIVY;
      ST_DIVY:      if (cnt_r == CNT_W'(DIV_ITER - 1)) state_nxt = ST_LENX;
      ST_LENX:      state_nxt = ST_LENY;
      ST_LENY:      state_nxt = ST_WSTART;
      ST_WSTART:    state_nxt = ST_WALK;
      ST_WALK: begin
        if (sts.walk_hit)      state_nxt = ST_HX;
        else if (sts.walk_end) state_nxt = ST_FIN;
      end
      ST_HX:        state_nxt = ST_HY;
      ST_HY:        state_nxt = ST_HYF;
      ST_HYF:       state_nxt = ST_FIN;
      ST_FIN:       if (!sts.out_busy) state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  // iteration counter: runs in the sweeping states, zero elsewhere
  always_comb begin
    cnt_nxt = '0;
    if ((state_r == ST_CLEAR || state_r == ST_SQRT || state_r == ST_DIVX ||
         state_r == ST_DIVY) && (state_nxt == state_r))
      cnt_nxt = cnt_r + CNT_W'(1);
  end

  // outputs
  always_comb begin
    cmd.op   = DP_NOP;
    cmd.addr = cnt_r[ADDR_W-1:0];
    unique case (state_r)
      ST_CLEAR:     cmd.op = DP_CLEAR;
      ST_IDLE:      cmd.op = accept ? DP_ACCEPT : DP_NOP;
      ST_SQX:       cmd.op = DP_SQX;
      ST_SQY:       cmd.op = DP_SQY;
      ST_SQSUM:     cmd.op = DP_SQSUM;
      ST_SQRT:      cmd.op = DP_SQRT;
      ST_DIVX_INIT: cmd.op = DP_DIVX_INIT;
      ST_DIVX:      cmd.op = DP_DIV;
      ST_DIVY_INIT: cmd.op = DP_DIVY_INIT;
      ST_DIVY:      cmd.op = DP_DIV;
      ST_LENX:      cmd.op = DP_LENX;
      ST_LENY:      cmd.op = DP_LENY;
      ST_WSTART:    cmd.op = DP_WSTART;
      ST_WALK:      cmd.op = DP_WALK;
      ST_HX:        cmd.op = DP_HX;
      ST_HY:        cmd.op = DP_HY;
      ST_HYF:       cmd.op = DP_HYF;
      ST_FIN:       cmd.op = sts.out_busy ? DP_NOP : DP_FIN;
      default:      cmd.op = DP_NOP;
    endcase
  end

endmodule

// File: hdl/gdrc_dp.sv
// ----------------------------------------------------------------------------
// gdrc_dp
// Datapath: grid memory, shared multiplier, root and divider, DDA walker.
// ----------------------------------------------------------------------------
module gdrc_dp
  import gdrc_pkg::*;
`include "grid_dda_ray_caster_unit_defines.svh"
(
  input  logic          clk,
  input  logic          rst_n,
  input  dp_cmd_t       cmd,
  output dp_sts_t       sts,
  input  logic          in_mode,
  input  logic [5:0]    in_cell_x,
  input  logic [5:0]    in_cell_y,
  input  logic          in_cell_solid,
  input  logic [15:0]   in_origin_x,
  input  logic [15:0]   in_origin_y,
  input  logic [15:0]   in_dir_x,
  input  logic [15:0]   in_dir_y,
  input  logic          cfg_we,
  input  logic [7:0]    cfg_wdata,
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic          out_hit,
  output logic [15:0]   out_distance,
  output logic [16:0]   out_hit_x,
  output logic [16:0]   out_hit_y
);

  // configuration
  logic [7:0] max_dist_r;
  always_ff @(posedge clk) begin
    if (!rst_n)      max_dist_r <= MAX_DIST_RESET;
    else if (cfg_we) max_dist_r <= cfg_wdata;
  end

  // cast operands
  logic [15:0]        ox_r, oy_r, adx_r, ady_r;
  logic signed [15:0] dx_r, dy_r;

  // arithmetic state
  logic signed [35:0] prod_r;
  logic signed [17:0] mul_a, mul_b;
  logic [31:0]        sq_r;
  logic [17:0]        srem_r;
  logic [15:0]        root_r;
  logic [23:0]        dvd_r, quot_r;
  logic [15:0]        drem_r, dvs_r;
  logic [15:0]        ux_r, uy_r, lx_r, ly_r, dist_r;
  logic signed [COORD_W-1:0] mx_r, my_r;
  logic               pend_r, inb_r, hit_r, rd_r;
  logic [16:0]        hx_r, hy_r;

  // output register
  logic        out_valid_r, out_hit_r;
  logic [15:0] out_dist_r;
  logic [16:0] out_hx_r, out_hy_r;

  // memory
  logic              mem [DEPTH];
  logic              mem_we, mem_wd;
  logic [ADDR_W-1:0] mem_wa, mem_ra;

  // ---- combinational pieces ----
  logic [19:0] s_sh, s_trial, s_diff;
  logic        s_ge;
  logic [16:0] d_sh, d_diff;
  logic        d_ge;
  logic [15:0] quot_sat;
  logic [10:0] part_x, part_y;
  logic [15:0] len_sat;
  logic        step_x;
  logic signed [COORD_W-1:0] nmx, nmy;
  logic [15:0] ndist, nlx, nly;
  logic [16:0] lsum;
  logic        ninb;
  logic [15:0] limit;
  logic        walk_hit, walk_end, do_step;
  logic [16:0] hc_sat;
  logic [15:0] hc_org;
  logic signed [33:0] hc_acc;
  logic signed [19:0] hc_sh;
  logic        wr_inb;

  assign s_sh    = {srem_r, sq_r[31:30]};
  assign s_trial = {2'b00, root_r, 2'b01};
  assign s_ge    = (s_sh >= s_trial);
  assign s_diff  = s_sh - s_trial;

  assign d_sh    = {drem_r, dvd_r[23]};
  assign d_ge    = (d_sh >= {1'b0, dvs_r});
  assign d_diff  = d_sh - {1'b0, dvs_r};

  assign quot_sat = (quot_r[23:16] != 8'd0) ? SAT16 : quot_r[15:0];

  assign part_x = dx_r[15] ? {1'b0, ox_r[9:0]} : (11'd1024 - {1'b0, ox_r[9:0]});
  assign part_y = dy_r[15] ? {1'b0, oy_r[9:0]} : (11'd1024 - {1'b0, oy_r[9:0]});
  // part * unit <= 1024 * 65535, so the shifted value never exceeds 16 bits
  assign len_sat = (prod_r[35:26] != 10'd0) ? SAT16 : prod_r[25:10];

  always_comb begin
    unique case (cmd.op)
      DP_SQX:  begin mul_a = {2'b00, adx_r};   mul_b = {2'b00, adx_r};  end
      DP_SQY:  begin mul_a = {2'b00, ady_r};   mul_b = {2'b00, ady_r};  end
      DP_LENX: begin mul_a = {7'd0, part_x};   mul_b = {2'b00, ux_r};   end
      DP_LENY: begin mul_a = {7'd0, part_y};   mul_b = {2'b00, uy_r};   end
      DP_HX:   begin mul_a = 18'(dx_r);        mul_b = {2'b00, dist_r}; end
      DP_HY:   begin mul_a = 18'(dy_r);        mul_b = {2'b00, dist_r}; end
      default: begin mul_a = '0;               mul_b = '0;              end
    endcase
  end

  // DDA step
  assign limit  = {max_dist_r, 8'd0};
  assign step_x = (lx_r < ly_r);
  assign lsum   = step_x ? ({1'b0, lx_r} + {1'b0, ux_r}) : ({1'b0, ly_r} + {1'b0, uy_r});
  assign ndist  = step_x ? lx_r : ly_r;
  assign nlx    = (step_x) ? (lsum[16] ? SAT16 : lsum[15:0]) : lx_r;
  assign nly    = (!step_x) ? (lsum[16] ? SAT16 : lsum[15:0]) : ly_r;
  assign nmx    = step_x ? (dx_r[15] ? mx_r - COORD_W'(1) : mx_r + COORD_W'(1)) : mx_r;
  assign nmy    = !step_x ? (dy_r[15] ? my_r - COORD_W'(1) : my_r + COORD_W'(1)) : my_r;
  assign ninb   = !nmx[COORD_W-1] && ($unsigned(nmx) < COORD_W'(GRID_WIDTH)) &&
                  !nmy[COORD_W-1] && ($unsigned(nmy) < COORD_W'(GRID_HEIGHT));

  assign walk_hit = pend_r && inb_r && rd_r;
  assign walk_end = !walk_hit && (dist_r >= limit);
  assign do_step  = (cmd.op == DP_WALK) && !walk_hit && !walk_end;

  // hit coordinate: floor((origin*2^12 + dir*dist) / 2^14), clamped to 17 bits
  assign hc_org = (cmd.op == DP_HY) ? ox_r : oy_r;
  assign hc_acc = $signed({6'd0, hc_org, 12'd0}) + $signed(prod_r[33:0]);
  assign hc_sh  = hc_acc[33:14];
  always_comb begin
    if (hc_sh < -20'sd65536)     hc_sat = 17'h10000;
    else if (hc_sh > 20'sd65535) hc_sat = 17'h0FFFF;
    else                         hc_sat = hc_sh[16:0];
  end

  // grid memory ports
  assign wr_inb = (int'(in_cell_x) < GRID_WIDTH) && (int'(in_cell_y) < GRID_HEIGHT);
  assign mem_we = (cmd.op == DP_CLEAR) || (cmd.op == DP_ACCEPT && !in_mode && wr_inb);
  assign mem_wd = (cmd.op == DP_CLEAR) ? 1'b0 : in_cell_solid;
  assign mem_wa = (cmd.op == DP_CLEAR) ? cmd.addr : cell_addr(int'(in_cell_x), int'(in_cell_y));
  assign mem_ra = cell_addr(int'(nmx[GW_BITS-1:0]), int'(nmy[GH_BITS-1:0]));

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rd_r <= mem[mem_ra];
  end

  // payload registers
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    case (cmd.op)
      DP_ACCEPT: begin
        ox_r  <= in_origin_x;
        oy_r  <= in_origin_y;
        dx_r  <= $signed(in_dir_x);
        dy_r  <= $signed(in_dir_y);
        adx_r <= in_dir_x[15] ? 16'(-in_dir_x) : in_dir_x;
        ady_r <= in_dir_y[15] ? 16'(-in_dir_y) : in_dir_y;
      end
      DP_SQY:   sq_r <= prod_r[31:0];
      DP_SQSUM: begin
        sq_r   <= sq_r + prod_r[31:0];
        srem_r <= '0;
        root_r <= '0;
      end
      DP_SQRT: begin
        sq_r   <= {sq_r[29:0], 2'b00};
        srem_r <= s_ge ? s_diff[17:0] : s_sh[17:0];
        root_r <= {root_r[14:0], s_ge};
      end
      DP_DIVX_INIT: begin
        dvd_r  <= {root_r, 8'd0};
        dvs_r  <= adx_r;
        drem_r <= '0;
      end
      DP_DIV: begin
        dvd_r  <= {dvd_r[22:0], 1'b0};
        drem_r <= d_ge ? d_diff[15:0] : d_sh[15:0];
        quot_r <= {quot_r[22:0], d_ge};
      end
      DP_DIVY_INIT: begin
        ux_r   <= quot_sat;
        dvd_r  <= {root_r, 8'd0};
        dvs_r  <= ady_r;
        drem_r <= '0;
      end
      DP_LENX: uy_r <= quot_sat;
      DP_LENY: lx_r <= len_sat;
      DP_WSTART: begin
        ly_r   <= len_sat;
        mx_r   <= COORD_W'(ox_r[15:10]);
        my_r   <= COORD_W'(oy_r[15:10]);
        dist_r <= '0;
        pend_r <= 1'b0;
        hit_r  <= 1'b0;
      end
      DP_WALK: begin
        if (walk_hit) hit_r <= 1'b1;
        if (do_step) begin
          mx_r   <= nmx;
          my_r   <= nmy;
          lx_r   <= nlx;
          ly_r   <= nly;
          dist_r <= ndist;
          inb_r  <= ninb;
          pend_r <= 1'b1;
        end
      end
      DP_HY:  hx_r <= hc_sat;
      DP_HYF: hy_r <= hc_sat;
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.op == DP_FIN) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == DP_FIN) begin
      out_hit_r  <= hit_r;
      out_dist_r <= hit_r ? dist_r : 16'd0;
      out_hx_r   <= hit_r ? hx_r : 17'd0;
      out_hy_r   <= hit_r ? hy_r : 17'd0;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_hit      = out_hit_r;
  assign out_distance = out_dist_r;
  assign out_hit_x    = out_hx_r;
  assign out_hit_y    = out_hy_r;

  assign sts.is_cast  = in_mode;
  assign sts.walk_hit = walk_hit;
  assign sts.walk_end = walk_end;
  assign sts.out_busy = out_valid_r && !out_tready;

  `GDRC_ASSERT(a_fin_not_busy, (cmd.op == DP_FIN) |-> !(out_valid_r && !out_tready), "result loaded over an untaken one")
  `GDRC_ASSERT(a_miss_zero, (out_valid_r && !out_hit_r) |-> (out_dist_r == 16'd0 && out_hx_r == 17'd0 && out_hy_r == 17'd0), "miss result not cleared")
  `GDRC_ASSERT(a_dist_mono, ($past(cmd.op) == DP_WALK && cmd.op == DP_WALK) |-> (dist_r >= $past(dist_r)), "walk distance went backward")

endmodule

// File: hdl/grid_dda_ray_caster_unit.sv
// Write transaction: written to the grid in the accepting cycle, no result.
// Cast transaction: set-up (squares, 16-step root, two 24-step divides, start
//   lengths), then the walk, one grid cell per step until a hit or the limit, then
//   the finish; one transaction at a time, the walk sets the rate.
// Reset: synchronous, active low; a sweep of all 4096 cells then clears the grid,
//   during which in_tready stays low. The walk limit resets to 100.
// ----------------------------------------------------------------------------
// grid_dda_ray_caster_unit
// Occupancy grid with DDA ray casting: top level joining controller and datapath.
// ----------------------------------------------------------------------------
module grid_dda_ray_caster_unit
  import gdrc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  // [5:0] cell_x, [11:6] cell_y, [12] cell_solid, [28:13] origin_x,
  // [44:29] origin_y, [60:45] dir_x, [76:61] dir_y, [79:77] zero
  input  logic [79:0] in_tdata,
  // [0] mode: 0 = write cell, 1 = cast ray
  input  logic        in_tuser,
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  // [0] hit, [16:1] distance, [33:17] hit_x, [50:34] hit_y, [55:51] zero
  output logic [55:0] out_tdata,
  // configuration: walk limit in whole cells
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata
);

  dp_cmd_t     cmd;
  dp_sts_t     sts;
  logic        hit;
  logic [15:0] distance;
  logic [16:0] hit_x, hit_y;

  // controller: sequencing only, owns the iteration counter
  gdrc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath: grid bits, arithmetic, walker and result register
  gdrc_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_mode       (in_tuser),
    .in_cell_x     (in_tdata[5:0]),
    .in_cell_y     (in_tdata[11:6]),
    .in_cell_solid (in_tdata[12]),
    .in_origin_x   (in_tdata[28:13]),
    .in_origin_y   (in_tdata[44:29]),
    .in_dir_x      (in_tdata[60:45]),
    .in_dir_y      (in_tdata[76:61]),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_hit       (hit),
    .out_distance  (distance),
    .out_hit_x     (hit_x),
    .out_hit_y     (hit_y)
  );

  assign out_tdata = {5'd0, hit_y, hit_x, distance, hit};

endmodule
